// ===== design/lsr_pkg.sv =====
package lsr_pkg;

    localparam int IN_COORD_W   = 12;
    localparam int PIX_W        = 10;
    localparam int CFG_W        = 11;
    localparam int CFG_ADDR_W   = 1;
    localparam int IN_TDATA_W   = 4 * IN_COORD_W;
    localparam int OUT_TDATA_W  = 24;
    localparam int CANVAS_RESET = 600;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CANVAS_WIDTH  = 1'b0,
        REG_CANVAS_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // control handed from the input stage to the stepping engine
    typedef struct packed {
        logic valid;
        op_t  op;
    } item_ctrl_t;

endpackage

// ===== design/line_segment_rasterizer.sv =====
// Channel   Dir  Words                         Sideband
// cfg       in   cfg_addr (reg), cfg_data      -
// s_axis    in   start_x/start_y/end_x/end_y   tuser = opcode (0 load, 1 advance)
// m_axis    out  pixel_x/pixel_y               tlast = last_pixel
//
// One input word and one pixel per clock while m_axis is not stalled. An advance word is
// registered in the input stage, then its pixel in lsr_engine as the error accumulator steps.
// Endpoints are clamped in the input register stage, the segment is set up on the next edge.
// Reset sets both canvas sizes to 600 (or MAX_SIDE if less), dropping any segment in progress.
// A stalled output word holds an advance waiting in the input stage; tready is high otherwise.
module line_segment_rasterizer #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lsr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lsr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // start_x, start_y, end_x, end_y
    input  logic                             s_axis_tuser,   // opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // pixel_x, pixel_y, zero pad
    output logic                             m_axis_tlast
);

    localparam int CW = $clog2(MAX_SIDE);

    lsr_pkg::item_ctrl_t item;
    logic                take;
    logic [CW-1:0]       x1, y1, x2, y2;

    lsr_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item          (item),
        .x1            (x1),
        .y1            (y1),
        .x2            (x2),
        .y2            (y2)
    );

    lsr_engine #(
        .MAX_SIDE (MAX_SIDE)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .x1            (x1),
        .y1            (y1),
        .x2            (x2),
        .y2            (y2),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== design/lsr_front.sv =====
module lsr_front #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lsr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lsr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             take,
    output lsr_pkg::item_ctrl_t              item,
    output logic [$clog2(MAX_SIDE)-1:0]      x1,
    output logic [$clog2(MAX_SIDE)-1:0]      y1,
    output logic [$clog2(MAX_SIDE)-1:0]      x2,
    output logic [$clog2(MAX_SIDE)-1:0]      y2
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = (CW + 1 > lsr_pkg::CFG_W) ? CW + 1 : lsr_pkg::CFG_W;
    localparam int VW = (CW > lsr_pkg::IN_COORD_W) ? CW : lsr_pkg::IN_COORD_W;
    localparam int RST_SIDE = (lsr_pkg::CANVAS_RESET > MAX_SIDE) ? MAX_SIDE
                                                                  : lsr_pkg::CANVAS_RESET;
    localparam int CI = lsr_pkg::IN_COORD_W;

    // canvas limits kept as side - 1, the side already forced into [1, MAX_SIDE]
    logic [CW-1:0] lim_x_reg, lim_x_next;
    logic [CW-1:0] lim_y_reg, lim_y_next;
    logic [CW-1:0] lim_wr;
    logic [SW-1:0] side_wr;

    logic          valid_reg, valid_next;
    lsr_pkg::op_t  op_reg;
    logic [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic          accept;

    function automatic logic [CW-1:0] clamp(input logic [CI-1:0] v,
                                            input logic [CW-1:0] lim);
        logic [CW-1:0] r;
        begin
            if (v[CI-1])
            begin
                r = '0;
            end
            else if (VW'(v) > VW'(lim))
            begin
                r = lim;
            end
            else
            begin
                r = CW'(v);
            end
            return r;
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            side_wr = SW'(1);
        end
        else if (SW'(cfg_data) > SW'(MAX_SIDE))
        begin
            side_wr = SW'(MAX_SIDE);
        end
        else
        begin
            side_wr = SW'(cfg_data);
        end
        lim_wr = CW'(side_wr - SW'(1));
    end

    always_comb
    begin
        lim_x_next = lim_x_reg;
        lim_y_next = lim_y_reg;
        if (cfg_valid)
        begin
            unique case (lsr_pkg::cfg_reg_t'(cfg_addr))
                lsr_pkg::REG_CANVAS_WIDTH:  lim_x_next = lim_wr;
                lsr_pkg::REG_CANVAS_HEIGHT: lim_y_next = lim_wr;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_x_reg <= CW'(RST_SIDE - 1);
            lim_y_reg <= CW'(RST_SIDE - 1);
            valid_reg <= 1'b0;
        end
        else
        begin
            lim_x_reg <= lim_x_next;
            lim_y_reg <= lim_y_next;
            valid_reg <= valid_next;
        end
    end

    // endpoints are clamped on the way in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= lsr_pkg::op_t'(s_axis_tuser);
            x1_reg <= clamp(s_axis_tdata[CI-1:0], lim_x_reg);
            y1_reg <= clamp(s_axis_tdata[2*CI-1:CI], lim_y_reg);
            x2_reg <= clamp(s_axis_tdata[3*CI-1:2*CI], lim_x_reg);
            y2_reg <= clamp(s_axis_tdata[4*CI-1:3*CI], lim_y_reg);
        end
    end

    assign item.valid = valid_reg;
    assign item.op    = op_reg;
    assign x1 = x1_reg;
    assign y1 = y1_reg;
    assign x2 = x2_reg;
    assign y2 = y2_reg;

endmodule

// ===== design/lsr_engine.sv =====
module lsr_engine #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lsr_pkg::item_ctrl_t              item,
    input  logic [$clog2(MAX_SIDE)-1:0]      x1,
    input  logic [$clog2(MAX_SIDE)-1:0]      y1,
    input  logic [$clog2(MAX_SIDE)-1:0]      x2,
    input  logic [$clog2(MAX_SIDE)-1:0]      y2,
    output logic                             take,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int EW = CW + 2;
    localparam int PW = lsr_pkg::PIX_W;

    logic          busy_reg, busy_next;
    logic          steep_reg, steep_next;
    logic [CW-1:0] current_x_reg, current_x_next;
    logic [CW-1:0] current_y_reg, current_y_next;
    logic [CW-1:0] major_end_reg, major_end_next;
    logic [CW:0]   minor_delta2_reg, minor_delta2_next;   // 2*|d|
    logic [CW:0]   step_span_reg, step_span_next;         // 2*(M - |d|)
    logic          minor_direction_reg, minor_direction_next;
    logic [EW-1:0] rounding_error_reg, rounding_error_next;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] pix_x_reg, pix_y_reg;
    logic          last_reg;

    logic          is_load, is_adv, stall, produce;

    // load datapath
    logic [CW-1:0] adx, ady, major_d, minor_d;
    logic [CW-1:0] sx, sy, ex, ey;
    logic          ld_steep, ld_dir;

    // advance datapath
    logic [CW-1:0] major_pos;
    logic          last_px, minor_step;
    logic [CW-1:0] minor_pos, minor_moved;

    assign is_load = item.valid && (item.op == lsr_pkg::OP_LOAD);
    assign is_adv  = item.valid && (item.op == lsr_pkg::OP_ADVANCE);
    assign stall   = is_adv && busy_reg && out_valid_reg && !m_axis_tready;
    assign take    = item.valid && !stall;
    assign produce = take && is_adv && busy_reg;

    always_comb
    begin
        adx      = (x1 >= x2) ? x1 - x2 : x2 - x1;
        ady      = (y1 >= y2) ? y1 - y2 : y2 - y1;
        ld_steep = ady > adx;
        if (!ld_steep)
        begin
            if (x1 > x2)
            begin
                sx = x2; sy = y2; ex = x1; ey = y1;
            end
            else
            begin
                sx = x1; sy = y1; ex = x2; ey = y2;
            end
            major_d = adx;
            minor_d = ady;
            ld_dir  = ey < sy;
        end
        else
        begin
            if (y1 > y2)
            begin
                sx = x2; sy = y2; ex = x1; ey = y1;
            end
            else
            begin
                sx = x1; sy = y1; ex = x2; ey = y2;
            end
            major_d = ady;
            minor_d = adx;
            ld_dir  = ex < sx;
        end
    end

    // step when err + 2|d| reaches 2M, i.e. err >= 2(M - |d|)
    always_comb
    begin
        major_pos   = steep_reg ? current_y_reg : current_x_reg;
        minor_pos   = steep_reg ? current_x_reg : current_y_reg;
        last_px     = major_pos >= major_end_reg;
        minor_step  = rounding_error_reg >= EW'(step_span_reg);
        minor_moved = minor_direction_reg ? minor_pos - CW'(1) : minor_pos + CW'(1);
    end

    always_comb
    begin
        busy_next            = busy_reg;
        steep_next           = steep_reg;
        current_x_next       = current_x_reg;
        current_y_next       = current_y_reg;
        major_end_next       = major_end_reg;
        minor_delta2_next    = minor_delta2_reg;
        step_span_next       = step_span_reg;
        minor_direction_next = minor_direction_reg;
        rounding_error_next  = rounding_error_reg;

        if (take && is_load)
        begin
            busy_next            = 1'b1;
            steep_next           = ld_steep;
            current_x_next       = sx;
            current_y_next       = sy;
            major_end_next       = ld_steep ? ey : ex;
            minor_delta2_next    = {minor_d, 1'b0};
            step_span_next       = {CW'(major_d - minor_d), 1'b0};
            minor_direction_next = ld_dir;
            if (ld_dir && (major_d != '0))
            begin
                rounding_error_next = EW'(major_d - CW'(1));
            end
            else
            begin
                rounding_error_next = EW'(major_d);
            end
        end
        else if (produce)
        begin
            if (last_px)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (minor_step)
                begin
                    rounding_error_next = rounding_error_reg - EW'(step_span_reg);
                end
                else
                begin
                    rounding_error_next = rounding_error_reg + EW'(minor_delta2_reg);
                end
                if (steep_reg)
                begin
                    current_y_next = current_y_reg + CW'(1);
                    if (minor_step)
                    begin
                        current_x_next = minor_moved;
                    end
                end
                else
                begin
                    current_x_next = current_x_reg + CW'(1);
                    if (minor_step)
                    begin
                        current_y_next = minor_moved;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg            <= 1'b0;
            steep_reg           <= 1'b0;
            current_x_reg       <= '0;
            current_y_reg       <= '0;
            major_end_reg       <= '0;
            minor_delta2_reg    <= '0;
            step_span_reg       <= '0;
            minor_direction_reg <= 1'b0;
            rounding_error_reg  <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            busy_reg            <= busy_next;
            steep_reg           <= steep_next;
            current_x_reg       <= current_x_next;
            current_y_reg       <= current_y_next;
            major_end_reg       <= major_end_next;
            minor_delta2_reg    <= minor_delta2_next;
            step_span_reg       <= step_span_next;
            minor_direction_reg <= minor_direction_next;
            rounding_error_reg  <= rounding_error_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            pix_x_reg <= PW'(current_x_reg);
            pix_y_reg <= PW'(current_y_reg);
            last_reg  <= last_px;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(lsr_pkg::OUT_TDATA_W - 2 * PW){1'b0}}, pix_y_reg, pix_x_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== design/lsr_checker.sv =====
module lsr_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lsr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [lsr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [lsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             m_axis_tlast
);

    // a held output word keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // a fresh output word comes from an accepted word via the input and output registers
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output word without a matching input word");

    // input side only backs up behind a stalled output word
    a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with output free");

    // upper pad bits of the output word stay zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[lsr_pkg::OUT_TDATA_W-1:2*lsr_pkg::PIX_W] == '0)
        else $error("nonzero pad bits in output word");

endmodule

bind line_segment_rasterizer lsr_checker u_lsr_checker (.*);

// ===== test/line_segment_rasterizer_test.sv =====
`timescale 1ns / 100ps

module line_segment_rasterizer_test;

    localparam int SIDE_MAX    = 1024;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 94;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 8;
    localparam int LIMIT       = 400000;

    typedef struct packed {
        logic [lsr_pkg::PIX_W-1:0] x;
        logic [lsr_pkg::PIX_W-1:0] y;
        logic                      last;
    } pixel_t;

    typedef enum logic [1:0] {
        EXP_PRED,
        EXP_NONE,
        EXP_PIX
    } row_kind_t;

    typedef struct packed {
        lsr_pkg::op_t                          op;
        logic signed [lsr_pkg::IN_COORD_W-1:0] sx;
        logic signed [lsr_pkg::IN_COORD_W-1:0] sy;
        logic signed [lsr_pkg::IN_COORD_W-1:0] ex;
        logic signed [lsr_pkg::IN_COORD_W-1:0] ey;
        row_kind_t                             kind;
        logic [lsr_pkg::PIX_W-1:0]             px;
        logic [lsr_pkg::PIX_W-1:0]             py;
        logic                                  pl;
    } stim_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [lsr_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [lsr_pkg::CFG_W-1:0]          cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [lsr_pkg::IN_TDATA_W-1:0]     s_axis_tdata;   // start_x, start_y, end_x, end_y
    logic                               s_axis_tuser;   // opcode
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [lsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;   // pixel_x, pixel_y, zero pad
    logic                               m_axis_tlast;

    line_segment_rasterizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // directed words; typed pixels only where obvious, the rest via the shadow rasterizer
    stim_row_t stim_rows [25] = '{
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_NONE,   0, 0, 0},   // nothing loaded
        '{lsr_pkg::OP_LOAD,        5,     5,    5,     5, EXP_NONE,   0, 0, 0},   // single point
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PIX,    5, 5, 1},
        '{lsr_pkg::OP_LOAD,    -2048, -2048, 2047,  2047, EXP_NONE,   0, 0, 0},   // clamps both
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PIX,    0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PIX,    1, 1, 0},
        '{lsr_pkg::OP_LOAD,     2047, -2048, 2047, -2048, EXP_NONE,   0, 0, 0},   // drops busy
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PIX,  599, 0, 1},
        '{lsr_pkg::OP_LOAD,        5,     7,    3,     7, EXP_NONE,   0, 0, 0},   // horizontal
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_LOAD,        9,     4,    9,     3, EXP_NONE,   0, 0, 0},   // vertical
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_LOAD,        0,     0,    2,     1, EXP_NONE,   0, 0, 0},   // half up
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_LOAD,        4,     0,    0,     1, EXP_NONE,   0, 0, 0},   // falling minor
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0},
        '{lsr_pkg::OP_ADVANCE,     0,     0,    0,     0, EXP_PRED,   0, 0, 0}
    };

    logic [lsr_pkg::CFG_W-1:0] phase_w [PHASES] = '{600, 1024, 0, 2047, 1, 1024, 17, 0};
    logic [lsr_pkg::CFG_W-1:0] phase_h [PHASES] = '{600, 1024, 0, 2047, 1024, 1, 9, 0};

    // shadow copy of the block
    logic [lsr_pkg::CFG_W-1:0]  shadow_w = lsr_pkg::CANVAS_RESET;
    logic [lsr_pkg::CFG_W-1:0]  shadow_h = lsr_pkg::CANVAS_RESET;
    bit                         seg_busy;
    bit                         seg_steep;
    bit                         seg_dec;
    logic [lsr_pkg::PIX_W-1:0]  pos_x;
    logic [lsr_pkg::PIX_W-1:0]  pos_y;
    logic [lsr_pkg::PIX_W-1:0]  major_stop;
    logic [lsr_pkg::CFG_W-1:0]  major_span;
    logic [lsr_pkg::CFG_W-1:0]  minor_span;
    logic [12:0]                err_acc;

    pixel_t pixel_q [$];
    pixel_t want;
    int     mismatches;
    int     pixels_seen;
    int     stim_words;
    int     cycle_count;
    int     burst_left;
    int     gap_max;
    int     rdy_mode;
    bit     hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [lsr_pkg::CFG_W-1:0] side_eff(input logic [lsr_pkg::CFG_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > SIDE_MAX)
            return SIDE_MAX;
        return r;
    endfunction

    function automatic logic [lsr_pkg::PIX_W-1:0] clamp_to(
            input logic signed [lsr_pkg::IN_COORD_W-1:0] v,
            input logic [lsr_pkg::CFG_W-1:0] side);
        int vi;
        vi = v;
        if (vi < 0)
            return '0;
        if (vi >= int'(side))
            return lsr_pkg::PIX_W'(side - 1);
        return lsr_pkg::PIX_W'(vi);
    endfunction

    function automatic bit rasterize(input lsr_pkg::op_t op,
                                     input logic signed [lsr_pkg::IN_COORD_W-1:0] sx, sy, ex, ey,
                                     output pixel_t px);
        logic [lsr_pkg::PIX_W-1:0] x1, y1, x2, y2, tmp, major;
        logic [lsr_pkg::CFG_W-1:0] adx, ady;
        px = '0;
        if (op == lsr_pkg::OP_LOAD)
        begin
            x1 = clamp_to(sx, side_eff(shadow_w));
            y1 = clamp_to(sy, side_eff(shadow_h));
            x2 = clamp_to(ex, side_eff(shadow_w));
            y2 = clamp_to(ey, side_eff(shadow_h));
            adx = (x1 > x2) ? x1 - x2 : x2 - x1;
            ady = (y1 > y2) ? y1 - y2 : y2 - y1;
            seg_steep = ady > adx;
            if ((!seg_steep && x1 > x2) || (seg_steep && y1 > y2))
            begin
                tmp = x1; x1 = x2; x2 = tmp;
                tmp = y1; y1 = y2; y2 = tmp;
            end
            if (!seg_steep)
            begin
                major_span = adx;
                minor_span = ady;
                seg_dec    = y2 < y1;
                major_stop = x2;
            end
            else
            begin
                major_span = ady;
                minor_span = adx;
                seg_dec    = x2 < x1;
                major_stop = y2;
            end
            pos_x   = x1;
            pos_y   = y1;
            err_acc = (seg_dec && major_span != 0) ? 13'(major_span - 1) : 13'(major_span);
            seg_busy = 1'b1;
            return 1'b0;
        end
        if (!seg_busy)
            return 1'b0;
        major   = seg_steep ? pos_y : pos_x;
        px.x    = pos_x;
        px.y    = pos_y;
        px.last = major >= major_stop;
        if (px.last)
        begin
            seg_busy = 1'b0;
            return 1'b1;
        end
        err_acc = err_acc + 13'(2 * minor_span);
        if (seg_steep)
            pos_y = pos_y + 1;
        else
            pos_x = pos_x + 1;
        if (err_acc >= 13'(2 * major_span))
        begin
            err_acc = err_acc - 13'(2 * major_span);
            if (seg_steep)
                pos_x = seg_dec ? pos_x - 1 : pos_x + 1;
            else
                pos_y = seg_dec ? pos_y - 1 : pos_y + 1;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // one word through the input handshake; the shadow is stepped on acceptance
    task automatic send_word(input lsr_pkg::op_t op,
                             input logic signed [lsr_pkg::IN_COORD_W-1:0] sx, sy, ex, ey,
                             input bit to_queue, output bit made, output pixel_t px);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gap_max != 0)
                gap = $urandom_range(1, gap_max);
        end
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ey, ex, sy, sx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        made = rasterize(op, sx, sy, ex, ey, px);
        if (made && to_queue)
            pixel_q.insert(pixel_q.size(), px);
        if (made || op == lsr_pkg::OP_LOAD)
            stim_words++;
    endtask

    task automatic advance_one();
        bit     made;
        pixel_t px;
        send_word(lsr_pkg::OP_ADVANCE, 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 1'b1, made, px);
    endtask

    task automatic load_segment(input logic signed [lsr_pkg::IN_COORD_W-1:0] sx, sy, ex, ey);
        bit     made;
        pixel_t px;
        send_word(lsr_pkg::OP_LOAD, sx, sy, ex, ey, 1'b1, made, px);
    endtask

    task automatic settle_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_canvas(input lsr_pkg::cfg_reg_t idx,
                                input logic [lsr_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == lsr_pkg::REG_CANVAS_WIDTH)
            shadow_w = val;
        else
            shadow_h = val;
    endtask

    function automatic logic signed [lsr_pkg::IN_COORD_W-1:0] near_coord(
            input logic [lsr_pkg::CFG_W-1:0] side);
        int v;
        v = int'($urandom_range(0, side + 5)) - 3;
        return lsr_pkg::IN_COORD_W'(v);
    endfunction

    function automatic logic signed [lsr_pkg::IN_COORD_W-1:0] nudge(
            input logic signed [lsr_pkg::IN_COORD_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 24)) - 12;
        return lsr_pkg::IN_COORD_W'(v);
    endfunction

    task automatic run_phase(input int budget);
        int pick;
        int cap;
        int n;
        int first;
        logic signed [lsr_pkg::IN_COORD_W-1:0] sx, sy;
        first = stim_words;
        while (stim_words - first < budget)
        begin
            pick = $urandom_range(0, 99);
            sx = near_coord(side_eff(shadow_w));
            sy = near_coord(side_eff(shadow_h));
            if (pick < 70)
            begin
                // complete segment, sometimes an ignored advance after the end
                load_segment(sx, sy, nudge(sx), nudge(sy));
                cap = SIDE_MAX + 1;
            end
            else if (pick < 85)
            begin
                load_segment(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
                cap = $urandom_range(0, 40);
            end
            else if (pick < 95)
            begin
                // abandoned early, next load drops it
                load_segment(sx, sy, nudge(sx), nudge(sy));
                cap = $urandom_range(0, 3);
            end
            else
            begin
                cap = 0;
                repeat ($urandom_range(1, 3)) advance_one();
            end
            n = 0;
            while (seg_busy && n < cap)
            begin
                advance_one();
                n++;
            end
            if (cap > SIDE_MAX && $urandom_range(0, 3) == 0)
                advance_one();
        end
    endtask

    // output side: stall pattern per phase, plus one long hold-off
    initial
    begin
        int  hold_left;
        int  pat_cnt;
        bit  hold_done;
        hold_left = 0;
        pat_cnt   = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            pat_cnt++;
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rdy_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ((pat_cnt % 8) >= 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            pixels_seen++;
            if (pixel_q.size() == 0)
            begin
                flag_mismatch($sformatf("pixel (%0d,%0d) last=%0b with none pending",
                              m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tlast));
            end
            else
            begin
                want = pixel_q.pop_front();
                if (m_axis_tdata[9:0] != want.x)
                    flag_mismatch($sformatf("pixel_x %0d, want %0d", m_axis_tdata[9:0], want.x));
                if (m_axis_tdata[19:10] != want.y)
                    flag_mismatch($sformatf("pixel_y %0d, want %0d", m_axis_tdata[19:10], want.y));
                if (m_axis_tlast != want.last)
                    flag_mismatch($sformatf("last_pixel %0b, want %0b", m_axis_tlast, want.last));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d pixels outstanding", LIMIT, pixel_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        bit     made;
        pixel_t px;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = lsr_pkg::REG_CANVAS_WIDTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lsr_pkg::OP_LOAD;
        mismatches    = 0;
        pixels_seen   = 0;
        stim_words    = 0;
        burst_left    = 0;
        gap_max       = 3;
        rdy_mode      = 1;
        hold_request  = 1'b0;
        phase_w[PHASES-1] = lsr_pkg::CFG_W'($urandom_range(1, SIDE_MAX));
        phase_h[PHASES-1] = lsr_pkg::CFG_W'($urandom_range(1, SIDE_MAX));
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < 25; r++)
        begin
            send_word(stim_rows[r].op, stim_rows[r].sx, stim_rows[r].sy, stim_rows[r].ex,
                      stim_rows[r].ey, stim_rows[r].kind == EXP_PRED, made, px);
            if (stim_rows[r].kind == EXP_PIX)
                pixel_q.insert(pixel_q.size(),
                               pixel_t'{stim_rows[r].px, stim_rows[r].py, stim_rows[r].pl});
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                settle_idle();
                write_canvas(lsr_pkg::REG_CANVAS_WIDTH, phase_w[ph]);
                write_canvas(lsr_pkg::REG_CANVAS_HEIGHT, phase_h[ph]);
                @(negedge clk);
                cfg_valid <= 1'b0;
            end
            rdy_mode = ph % 3;
            gap_max  = (ph % 4 == 1) ? 0 : 2 + 3 * (ph % 4);
            if (ph == 0)
                hold_request = 1'b1;   // receiver backs off while the sender keeps pushing
            run_phase(PHASE_WORDS);
        end

        settle_idle();
        $display("Ran %0d words, checked %0d pixels across %0d canvas sizes",
                 stim_words, pixels_seen, PHASES);
        $display("Lines: points, axis-aligned, both slopes, clamped ends, dropped segments");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== line_segment_rasterizer.f =====
design/lsr_pkg.sv
design/lsr_front.sv
design/lsr_engine.sv
design/line_segment_rasterizer.sv
design/lsr_checker.sv
test/line_segment_rasterizer_test.sv
